// File: sv/stq_pkg.sv
// Shared types and constants of the software timer queue.
package stq_pkg;

    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_DESTROY = 3'd1;
    localparam logic [2:0] MODE_SERVICE = 3'd2;
    localparam logic [2:0] MODE_SET     = 3'd3;
    localparam logic [2:0] MODE_DELTAG  = 3'd4;
    localparam logic [2:0] MODE_GET     = 3'd5;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TIME  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_ACT   = 3'd3;
    localparam logic [2:0] ST_NO_SET    = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    localparam logic [1:0] ATTR_TYPE   = 2'd0;
    localparam logic [1:0] ATTR_EXPIRY = 2'd1;
    localparam logic [1:0] ATTR_REPEAT = 2'd2;
    localparam logic [1:0] ATTR_TAG    = 2'd3;

    localparam logic [14:0] MSG_TYPE    = 15'd8;
    localparam logic [5:0]  SERVICE_CAP = 6'd63;

    typedef struct packed {
        logic [14:0] typ;
        logic [31:0] expiry;
        logic [30:0] rpt;
        logic [31:0] tag;
        logic [31:0] order;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SCAN,
        S_SVC_CHECK
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_REPLY,
        EM_EVENT,
        EM_COUNT,
        EM_GET
    } t_emit;

    typedef enum logic [1:0] {
        SL_ZERO,
        SL_HANDLE,
        SL_FREE,
        SL_BEST
    } t_slot_sel;

    typedef struct packed {
        logic      latch;
        logic      scan_start;
        logic      rd_handle;
        logic      wr_create;
        logic      wr_set;
        logic      wr_reload;
        logic      clr_handle;
        logic      clr_best;
        logic      cnt_clr;
        logic      cnt_inc;
        t_emit     emit;
        logic [2:0] status;
        t_slot_sel slot_sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       scan_done;
        logic       free_found;
        logic       best_found;
        logic       best_due;
        logic       best_periodic;
        logic       handle_ok;
        logic       delay_zero;
        logic       mask_zero;
        logic       set_bad;
        logic       cnt_done;
    } t_sts;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: sv/software_timer_queue.sv
// Top level of the software timer queue.
//
//  Channel   Handshake              Payload
//  command   start / busy           i_mode .. i_attribute
//  result    o_valid (one cycle)    o_kind .. o_last
//
// Destroy, set and get need no scan; create and delete by tag run one scan
// of the table, which reads one table entry per cycle.
// Service repeats the scan, raising one expiry per scan, until no due timer
// is left or the service limit ends it.
// Reset is synchronous and clears every timer; no clearing pass is needed.
// Results cannot be held off; busy falls in the cycle that carries the last one.
module software_timer_queue import stq_pkg::*; #(
    parameter int NUM_TIMERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_now,
    input  logic [4:0]  i_handle,
    input  logic [14:0] i_timer_type,
    input  logic [30:0] i_delay,
    input  logic [30:0] i_repeat_req,
    input  logic [31:0] i_tag,
    input  logic [5:0]  i_service_limit,
    input  logic        i_service_all,
    input  logic [3:0]  i_set_mask,
    input  logic [1:0]  i_attribute,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [14:0] o_event_type,
    output logic [31:0] o_event_tag,
    output logic [31:0] o_value,
    output logic        o_last
);
    t_cmd cmd;
    t_sts sts;

    stq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stq_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_now           (i_now),
        .i_handle        (i_handle),
        .i_timer_type    (i_timer_type),
        .i_delay         (i_delay),
        .i_repeat_req    (i_repeat_req),
        .i_tag           (i_tag),
        .i_service_limit (i_service_limit),
        .i_service_all   (i_service_all),
        .i_set_mask      (i_set_mask),
        .i_attribute     (i_attribute),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_event_type    (o_event_type),
        .o_event_tag     (o_event_tag),
        .o_value         (o_value),
        .o_last          (o_last)
    );
endmodule

// File: sv/stq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/stq_datapath.sv
// Timer table datapath: active bits, entry memory, scan unit and result registers.
module stq_datapath import stq_pkg::*; #(
    parameter int NUM_TIMERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_now,
    input  logic [4:0]  i_handle,
    input  logic [14:0] i_timer_type,
    input  logic [30:0] i_delay,
    input  logic [30:0] i_repeat_req,
    input  logic [31:0] i_tag,
    input  logic [5:0]  i_service_limit,
    input  logic        i_service_all,
    input  logic [3:0]  i_set_mask,
    input  logic [1:0]  i_attribute,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [14:0] o_event_type,
    output logic [31:0] o_event_tag,
    output logic [31:0] o_value,
    output logic        o_last
);
    localparam int AW = $clog2(NUM_TIMERS);
    localparam int IW = $clog2(NUM_TIMERS + 1);
    localparam int EW = $bits(t_entry);

    logic [2:0]  r_mode;
    logic [31:0] r_now;
    logic [4:0]  r_handle;
    logic [14:0] r_ttype;
    logic [30:0] r_delay;
    logic [30:0] r_rep;
    logic [31:0] r_tag;
    logic [5:0]  r_limit;
    logic        r_all;
    logic [3:0]  r_mask;
    logic [1:0]  r_attr;

    logic [NUM_TIMERS-1:0] r_active;
    logic [31:0]           r_next_order;
    logic [IW-1:0]         r_idx;
    logic                  r_scan_run;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_free_vld;
    logic [AW-1:0]         r_free_idx;
    logic                  r_best_vld;
    logic [AW-1:0]         r_best_idx;
    t_entry                r_best;
    logic [5:0]            r_cnt;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [2:0]  r_status;
    logic [4:0]  r_slot;
    logic [14:0] r_etype;
    logic [31:0] r_etag;
    logic [31:0] r_value;
    logic        r_last;

    logic [AW-1:0] hidx;
    logic          iss;
    logic          scan_done;
    logic          cand;
    logic          better;
    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [EW-1:0] rdata_raw;
    t_entry        rd;
    logic [AW-1:0] raddr;
    logic [AW-1:0] slot_idx;
    logic [5:0]    cap;

    assign hidx      = AW'(r_handle);
    assign iss       = r_scan_run && (r_idx < IW'(NUM_TIMERS));
    assign scan_done = r_scan_run && (r_idx == IW'(NUM_TIMERS)) && !r_rd_vld;
    assign raddr     = i_cmd.rd_handle ? hidx : r_idx[AW-1:0];
    assign rd        = t_entry'(rdata_raw);
    assign cap       = r_all ? SERVICE_CAP : r_limit;

    stq_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (EW'(wdata)),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        cand = r_rd_vld && r_active[r_rd_idx] &&
               ((r_mode != MODE_DELTAG) || ((rd.typ == MSG_TYPE) && (rd.tag == r_tag)));
        better = !r_best_vld || (rd.expiry < r_best.expiry) ||
                 ((rd.expiry == r_best.expiry) && (rd.order < r_best.order));
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_free_idx;
        wdata = r_best;
        if (i_cmd.wr_create) begin
            we          = 1'b1;
            waddr       = r_free_idx;
            wdata.typ   = r_ttype;
            wdata.expiry = sat_add(r_now, {1'b0, r_delay});
            wdata.rpt   = r_rep;
            wdata.tag   = r_tag;
            wdata.order = r_next_order;
        end else if (i_cmd.wr_set) begin
            we    = 1'b1;
            waddr = hidx;
            wdata = rd;
            if (r_mask[0]) wdata.typ = r_ttype;
            if (r_mask[1]) wdata.rpt = r_rep;
            if (r_mask[2]) wdata.tag = r_tag;
            if (r_mask[3]) wdata.expiry = sat_add(r_now, {1'b0, r_delay});
        end else if (i_cmd.wr_reload) begin
            we           = 1'b1;
            waddr        = r_best_idx;
            wdata        = r_best;
            wdata.expiry = sat_add(r_best.expiry, {1'b0, r_best.rpt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode   <= i_mode;
            r_now    <= i_now;
            r_handle <= i_handle;
            r_ttype  <= i_timer_type;
            r_delay  <= i_delay;
            r_rep    <= i_repeat_req;
            r_tag    <= i_tag;
            r_limit  <= i_service_limit;
            r_all    <= i_service_all;
            r_mask   <= i_set_mask;
            r_attr   <= i_attribute;
        end
        if (iss) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (iss && !r_free_vld && !r_active[r_idx[AW-1:0]]) begin
            r_free_idx <= r_idx[AW-1:0];
        end
        if (cand && better) begin
            r_best     <= rd;
            r_best_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_next_order <= '0;
            r_idx        <= '0;
            r_scan_run   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_free_vld   <= 1'b0;
            r_best_vld   <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_rd_vld <= iss;
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_scan_run <= 1'b1;
                r_free_vld <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                if (iss) begin
                    r_idx <= r_idx + IW'(1);
                    if (!r_active[r_idx[AW-1:0]]) begin
                        r_free_vld <= 1'b1;
                    end
                end
                if (scan_done) begin
                    r_scan_run <= 1'b0;
                end
                if (cand) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.wr_create) begin
                r_active[r_free_idx] <= 1'b1;
                r_next_order         <= r_next_order + 32'd1;
            end
            if (i_cmd.clr_handle) begin
                r_active[hidx] <= 1'b0;
            end
            if (i_cmd.clr_best) begin
                r_active[r_best_idx] <= 1'b0;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.slot_sel)
            SL_ZERO:   slot_idx = '0;
            SL_HANDLE: slot_idx = hidx;
            SL_FREE:   slot_idx = r_free_idx;
            SL_BEST:   slot_idx = r_best_idx;
            default:   slot_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.emit != EM_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= KIND_REPLY;
        r_status <= i_cmd.status;
        r_slot   <= '0;
        r_etype  <= '0;
        r_etag   <= '0;
        r_value  <= '0;
        r_last   <= 1'b1;
        unique case (i_cmd.emit)
            EM_REPLY: begin
                r_slot <= (i_cmd.slot_sel == SL_HANDLE) ? r_handle : 5'(slot_idx);
            end
            EM_GET: begin
                r_slot <= r_handle;
                unique case (r_attr)
                    ATTR_TYPE:   r_value <= {17'd0, rd.typ};
                    ATTR_EXPIRY: r_value <= rd.expiry;
                    ATTR_REPEAT: r_value <= {1'b0, rd.rpt};
                    ATTR_TAG:    r_value <= rd.tag;
                    default:     r_value <= '0;
                endcase
            end
            EM_EVENT: begin
                r_kind   <= KIND_EVENT;
                r_status <= ST_OK;
                r_slot   <= 5'(r_best_idx);
                r_etype  <= r_best.typ;
                r_etag   <= r_best.tag;
                r_last   <= 1'b0;
            end
            EM_COUNT: begin
                r_kind   <= KIND_COUNT;
                r_status <= ST_OK;
                r_value  <= {26'd0, r_cnt};
            end
            default: begin
                r_last <= 1'b1;
            end
        endcase
    end

    always_comb begin
        o_sts.mode          = r_mode;
        o_sts.scan_done     = scan_done;
        o_sts.free_found    = r_free_vld;
        o_sts.best_found    = r_best_vld;
        o_sts.best_due      = r_best.expiry <= r_now;
        o_sts.best_periodic = r_best.rpt != '0;
        o_sts.handle_ok     = (int'(r_handle) < NUM_TIMERS) && r_active[hidx];
        o_sts.delay_zero    = r_delay == '0;
        o_sts.mask_zero     = r_mask == '0;
        o_sts.set_bad       = r_mask[3] && (r_delay == '0);
        o_sts.cnt_done      = r_cnt >= cap;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_event_type = r_etype;
    assign o_event_tag  = r_etag;
    assign o_value      = r_value;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && iss)) else $error("table write while the scan reads");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_cnt < SERVICE_CAP)) else $error("service count overrun");
    a_create_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_create |-> r_free_vld) else $error("create without a free slot");
`endif
endmodule

// File: sv/stq_ctrl.sv
// Command sequencer of the software timer queue.
module stq_ctrl import stq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority case (i_sts.mode)
                    MODE_CREATE:  n_state = i_sts.delay_zero ? S_IDLE : S_SCAN;
                    MODE_SERVICE: n_state = S_SVC_CHECK;
                    MODE_DELTAG:  n_state = S_SCAN;
                    MODE_SET:     n_state = (i_sts.handle_ok && !i_sts.mask_zero &&
                                             !i_sts.set_bad) ? S_RD_WAIT : S_IDLE;
                    MODE_GET:     n_state = i_sts.handle_ok ? S_RD_WAIT : S_IDLE;
                    default:      n_state = S_IDLE;
                endcase
            end
            S_RD_WAIT: n_state = S_IDLE;
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.mode == MODE_SERVICE && i_sts.best_found && i_sts.best_due) begin
                        n_state = S_SVC_CHECK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SVC_CHECK: n_state = i_sts.cnt_done ? S_IDLE : S_SCAN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.emit     = EM_NONE;
        o_cmd.status   = ST_OK;
        o_cmd.slot_sel = SL_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
            end
            S_DECODE: begin
                priority case (i_sts.mode)
                    MODE_CREATE: begin
                        if (i_sts.delay_zero) begin
                            o_cmd.emit   = EM_REPLY;
                            o_cmd.status = ST_BAD_TIME;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    MODE_DESTROY: begin
                        o_cmd.emit       = EM_REPLY;
                        o_cmd.slot_sel   = SL_HANDLE;
                        o_cmd.status     = i_sts.handle_ok ? ST_OK : ST_NOT_ACT;
                        o_cmd.clr_handle = i_sts.handle_ok;
                    end
                    MODE_SERVICE: o_cmd.cnt_clr = 1'b1;
                    MODE_DELTAG:  o_cmd.scan_start = 1'b1;
                    MODE_SET: begin
                        o_cmd.slot_sel = SL_HANDLE;
                        if (!i_sts.handle_ok) begin
                            o_cmd.emit   = EM_REPLY;
                            o_cmd.status = ST_NOT_ACT;
                        end else if (i_sts.mask_zero) begin
                            o_cmd.emit   = EM_REPLY;
                            o_cmd.status = ST_NO_SET;
                        end else if (i_sts.set_bad) begin
                            o_cmd.emit   = EM_REPLY;
                            o_cmd.status = ST_BAD_TIME;
                        end else begin
                            o_cmd.rd_handle = 1'b1;
                        end
                    end
                    MODE_GET: begin
                        o_cmd.slot_sel = SL_HANDLE;
                        if (!i_sts.handle_ok) begin
                            o_cmd.emit   = EM_REPLY;
                            o_cmd.status = ST_NOT_ACT;
                        end else begin
                            o_cmd.rd_handle = 1'b1;
                        end
                    end
                    default: o_cmd.emit = EM_NONE;
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.slot_sel = SL_HANDLE;
                if (i_sts.mode == MODE_SET) begin
                    o_cmd.wr_set = 1'b1;
                    o_cmd.emit   = EM_REPLY;
                end else begin
                    o_cmd.emit = EM_GET;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    priority case (i_sts.mode)
                        MODE_CREATE: begin
                            o_cmd.emit = EM_REPLY;
                            if (i_sts.free_found) begin
                                o_cmd.wr_create = 1'b1;
                                o_cmd.slot_sel  = SL_FREE;
                            end else begin
                                o_cmd.status = ST_FULL;
                            end
                        end
                        MODE_DELTAG: begin
                            o_cmd.emit = EM_REPLY;
                            if (i_sts.best_found) begin
                                o_cmd.clr_best = 1'b1;
                                o_cmd.slot_sel = SL_BEST;
                            end else begin
                                o_cmd.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (i_sts.best_found && i_sts.best_due) begin
                                o_cmd.emit      = EM_EVENT;
                                o_cmd.cnt_inc   = 1'b1;
                                o_cmd.wr_reload = i_sts.best_periodic;
                                o_cmd.clr_best  = !i_sts.best_periodic;
                            end else begin
                                o_cmd.emit = EM_COUNT;
                            end
                        end
                    endcase
                end
            end
            S_SVC_CHECK: begin
                if (i_sts.cnt_done) begin
                    o_cmd.emit = EM_COUNT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            default: o_cmd.emit = EM_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_event_in_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit == EM_EVENT) |-> (r_state == S_SCAN && i_sts.mode == MODE_SERVICE))
        else $error("expiry event outside service");
    a_inc_with_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> (o_cmd.emit == EM_EVENT)) else $error("count without event");
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_WAIT) |=> (r_state == S_IDLE)) else $error("read wait stuck");
`endif
endmodule
